### rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_WRITE    = 3'd3;
  localparam logic [2:0] OP_WAIT_ACK = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;
  localparam logic [2:0] OP_SEND_ACK = 3'd6;
  localparam logic [2:0] OP_RSVD     = 3'd7;

  // Command phase codes; the meaning of each phase depends on the command.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_POLL   = 3'd3;
  localparam logic [2:0] PH_TO_LOW = 3'd4;
  localparam logic [2:0] PH_TO_HI  = 3'd5;

  // Register indexes on the configuration port.
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_POLLS   = 1'b1;

  // Register reset values.
  localparam logic [15:0] HALF_PERIOD_RST = 16'd40;
  localparam logic [7:0]  ACK_POLLS_RST   = 8'd250;

  // Bits in one byte transfer.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  ack_polls;
  } i2cm_cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  cmd;
    logic [3:0]  bit_cnt;
    logic [15:0] tick_cnt;
    logic [7:0]  poll_cnt;
    logic [7:0]  shift;
    logic        scl;
    logic        sda;
    logic        drive;
    logic        tmo;
    logic [7:0]  rx_hold;
  } i2cm_state_t;

  localparam i2cm_state_t STATE_RST = '{
    phase:    PH_IDLE,
    cmd:      OP_NONE,
    bit_cnt:  4'd0,
    tick_cnt: 16'd0,
    poll_cnt: 8'd0,
    shift:    8'd0,
    scl:      1'b1,
    sda:      1'b1,
    drive:    1'b1,
    tmo:      1'b0,
    rx_hold:  8'd0
  };

endpackage

`default_nettype wire

### rtl/i2c_master_bit_sequencer_core.sv
// The result of an input transfer appears on the output register in the next cycle.
// Throughput: one tick item per cycle unless the output stalls (single-tick update).
// A result waiting on the output lets the next tick in as soon as it is taken.
// Reset (rst, synchronous, active high) idles the sequencer with SCL and SDA
// driven high, loads the register defaults and empties the output register.
`default_nettype none

module i2c_master_bit_sequencer_core
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick input: op[2:0], tx_byte[10:3], ack_level[11], sda_sample[12], zero[15:13].
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  // Result: scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // rx_byte[12:5], ack_timeout[13], zero[15:14].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  i2cm_cfg_t   cfg;
  i2cm_state_t state;
  i2cm_state_t state_next;
  logic        done_next;
  logic        in_xfer;

  i2cm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cm_step u_step (
    .cur        (state),
    .cfg        (cfg),
    .op         (s_axis_tdata[2:0]),
    .tx_byte    (s_axis_tdata[10:3]),
    .ack_level  (s_axis_tdata[11]),
    .sda_sample (s_axis_tdata[12]),
    .nxt        (state_next),
    .done       (done_next)
  );

  // A new tick enters whenever the output register is empty or being drained.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RST;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Output register holds the bus levels and status after the tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= {2'b00, state_next.tmo, state_next.rx_hold, done_next,
                       (state_next.phase != PH_IDLE), state_next.drive,
                       state_next.sda, state_next.scl};
    end
  end

  // An accepted tick always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // A finished command never reports busy on the same tick.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done and busy set together");

  // An active sequence always belongs to a real command.
  assert property (@(posedge clk) disable iff (rst)
    state.phase != PH_IDLE |-> (state.cmd != OP_NONE && state.cmd != OP_RSVD))
    else $error("active phase without a command");

  // The bit counter never runs past one byte.
  assert property (@(posedge clk) disable iff (rst) state.bit_cnt <= BITS_PER_BYTE)
    else $error("bit counter overran a byte");

  // The tick counter stays below the half period while a command runs.
  assert property (@(posedge clk) disable iff (rst)
    state.phase != PH_IDLE && cfg.half_period != 16'd0 |->
      state.tick_cnt < cfg.half_period)
    else $error("tick counter reached the half period");

endmodule

`default_nettype wire

### rtl/i2cm_apb_regs.sv
`default_nettype none

module i2cm_apb_regs
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output i2cm_cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes, decoded on the word address.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= HALF_PERIOD_RST;
      cfg.ack_polls   <= ACK_POLLS_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_HALF_PERIOD: cfg.half_period <= pwdata[15:0];
        REG_ACK_POLLS:   cfg.ack_polls   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[2])
      REG_HALF_PERIOD: prdata = {16'd0, cfg.half_period};
      REG_ACK_POLLS:   prdata = {24'd0, cfg.ack_polls};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/i2cm_step.sv
`default_nettype none

module i2cm_step
  import i2cm_pkg::*;
(
  input  wire i2cm_state_t cur,
  input  wire i2cm_cfg_t   cfg,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        ack_level,
  input  wire logic        sda_sample,
  output i2cm_state_t      nxt,
  output logic             done
);

  logic [15:0] limit;
  logic [16:0] tick_sum;
  logic [3:0]  bit_inc;

  always_comb begin
    nxt      = cur;
    done     = 1'b0;
    limit    = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
    tick_sum = 17'd0;
    bit_inc  = 4'd0;

    // A command is taken only while idle; the accepting tick is its first tick.
    if (cur.phase == PH_IDLE && op != OP_NONE && op != OP_RSVD) begin
      nxt.cmd      = op;
      nxt.phase    = PH_FIRST;
      nxt.bit_cnt  = 4'd0;
      nxt.tick_cnt = 16'd0;
      nxt.poll_cnt = 8'd0;
      unique case (op)
        OP_START: begin
          nxt.drive = 1'b1; nxt.sda = 1'b1; nxt.scl = 1'b1;
        end
        OP_STOP: begin
          nxt.drive = 1'b1; nxt.sda = 1'b0; nxt.scl = 1'b1;
        end
        OP_WRITE: begin
          nxt.shift = tx_byte;
          nxt.drive = 1'b1; nxt.scl = 1'b0; nxt.sda = tx_byte[7];
        end
        OP_WAIT_ACK: begin
          nxt.tmo   = 1'b0;
          nxt.drive = 1'b0; nxt.sda = 1'b1; nxt.scl = 1'b0;
        end
        OP_READ: begin
          nxt.shift = 8'd0;
          nxt.drive = 1'b0; nxt.sda = 1'b1; nxt.scl = 1'b0;
        end
        default: begin
          nxt.drive = 1'b1; nxt.sda = ack_level; nxt.scl = 1'b0;
        end
      endcase
    end

    if (nxt.phase != PH_IDLE) begin
      if (nxt.cmd == OP_WAIT_ACK && nxt.phase == PH_POLL) begin
        // Acknowledge polling runs once per tick while SCL is high.
        if (!sda_sample) begin
          nxt.scl   = 1'b0;
          nxt.phase = PH_IDLE;
          done      = 1'b1;
        end else if (nxt.poll_cnt >= cfg.ack_polls) begin
          nxt.tmo      = 1'b1;
          nxt.drive    = 1'b1;
          nxt.scl      = 1'b1;
          nxt.sda      = 1'b0;
          nxt.tick_cnt = 16'd0;
          nxt.phase    = PH_TO_LOW;
        end else begin
          nxt.poll_cnt = nxt.poll_cnt + 8'd1;
        end
      end else begin
        tick_sum = {1'b0, nxt.tick_cnt} + 17'd1;
        if (tick_sum >= {1'b0, limit}) begin
          nxt.tick_cnt = 16'd0;
          bit_inc      = nxt.bit_cnt + 4'd1;
          // End of a half-bit phase.
          unique case (nxt.cmd)
            OP_START: begin
              if (nxt.phase == PH_FIRST) begin
                nxt.sda = 1'b0; nxt.phase = PH_SECOND;
              end else if (nxt.phase == PH_SECOND) begin
                nxt.phase = PH_POLL;
              end else begin
                nxt.scl = 1'b0; nxt.phase = PH_IDLE; done = 1'b1;
              end
            end
            OP_STOP: begin
              if (nxt.phase == PH_FIRST) begin
                nxt.sda = 1'b1; nxt.phase = PH_SECOND;
              end else begin
                nxt.phase = PH_IDLE; done = 1'b1;
              end
            end
            OP_WRITE: begin
              if (nxt.phase == PH_FIRST) begin
                nxt.scl = 1'b1; nxt.phase = PH_SECOND;
              end else begin
                nxt.bit_cnt = bit_inc;
                nxt.shift   = {nxt.shift[6:0], 1'b0};
                nxt.scl     = 1'b0;
                if (bit_inc >= BITS_PER_BYTE) begin
                  nxt.phase = PH_IDLE; done = 1'b1;
                end else begin
                  nxt.sda   = nxt.shift[7];
                  nxt.phase = PH_FIRST;
                end
              end
            end
            OP_WAIT_ACK: begin
              if (nxt.phase == PH_FIRST) begin
                nxt.scl = 1'b1; nxt.phase = PH_SECOND;
              end else if (nxt.phase == PH_SECOND) begin
                nxt.phase = PH_POLL;
              end else if (nxt.phase == PH_TO_LOW) begin
                nxt.sda = 1'b1; nxt.phase = PH_TO_HI;
              end else begin
                nxt.phase = PH_IDLE; done = 1'b1;
              end
            end
            OP_READ: begin
              if (nxt.phase == PH_FIRST) begin
                nxt.scl = 1'b1; nxt.phase = PH_SECOND;
              end else begin
                nxt.shift   = {nxt.shift[6:0], sda_sample};
                nxt.bit_cnt = bit_inc;
                nxt.scl     = 1'b0;
                if (bit_inc >= BITS_PER_BYTE) begin
                  nxt.rx_hold = nxt.shift;
                  nxt.phase   = PH_IDLE;
                  done        = 1'b1;
                end else begin
                  nxt.phase = PH_FIRST;
                end
              end
            end
            OP_SEND_ACK: begin
              if (nxt.phase == PH_FIRST) begin
                nxt.scl = 1'b1; nxt.phase = PH_SECOND;
              end else begin
                nxt.scl = 1'b0; nxt.phase = PH_IDLE; done = 1'b1;
              end
            end
            default: begin
              nxt.phase = PH_IDLE; done = 1'b1;
            end
          endcase
        end else begin
          nxt.tick_cnt = tick_sum[15:0];
        end
      end
    end
  end

endmodule

`default_nettype wire
